>>> sv/pai_pkg.sv
package pai_pkg;

  // Field widths
  localparam int ANGLE_W  = 16;
  localparam int TIME_W   = 32;
  localparam int SUM_W    = 32;
  localparam int VEL_W    = 32;
  localparam int WEIGHT_W = 9;
  localparam int LIMIT_W  = 15;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;
  localparam int REG_IDX_LSB = 2;

  // Velocity fixed point
  localparam int VEL_FRAC = 16;

  // Angle constants, radians * 8192
  localparam int ANG_PI  = 25736;
  localparam int ANG_2PI = 51472;

  // Smoothing weight is in 1/256 units
  localparam int WEIGHT_SHIFT = 8;
  localparam int WEIGHT_ONE   = 1 << WEIGHT_SHIFT;
  localparam int ROUND_BIAS   = WEIGHT_ONE - 1;
  localparam int WEIGHT_RESET = 218;
  localparam int LIMIT_RESET  = 1638;

  // Serial divider: |last_step| << VEL_FRAC over the last interval
  localparam int DIV_W     = ANGLE_W + VEL_FRAC;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int QX_W      = DIV_W + VEL_W;

  // Digit-serial multiplier
  localparam int DIFF_W     = VEL_W + 1;
  localparam int MUL_A_W    = DIFF_W;
  localparam int MUL_B_W    = TIME_W;
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
  localparam int MUL_S_W    = MUL_A_W + DIGIT_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  // Widths of the mix and prediction stages
  localparam int MIX_P_W = DIFF_W + WEIGHT_W;
  localparam int MIX_W   = MIX_P_W + 1;
  localparam int PM_W    = MUL_P_W - VEL_FRAC;
  localparam int WRAP_W  = ANGLE_W + 2;

  // Saturation bounds
  localparam logic [QX_W-1:0] QX_POS_MAX = QX_W'({1'b0, {(VEL_W-1){1'b1}}});
  localparam logic [QX_W-1:0] QX_NEG_MAX = QX_W'({1'b1, {(VEL_W-1){1'b0}}});
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Register indexes
  typedef enum logic {
    REG_WEIGHT = 1'b0,
    REG_LIMIT  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIFF,
    ST_MIX_GO,
    ST_MIX_MUL,
    ST_MIX_SHR,
    ST_PRED_GO,
    ST_PRED_MUL,
    ST_STEP,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                      start_series;
    logic [TIME_W-1:0]         sample_time;
    logic signed [ANGLE_W-1:0] sample_angle;
  } sample_t;

  typedef struct packed {
    logic [TIME_W-1:0]       elapsed_time;
    logic signed [SUM_W-1:0] integrated_angle;
    logic [TIME_W-1:0]       first_sample_time;
  } result_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [LIMIT_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

>>> sv/pai_cfg.sv
module pai_cfg import pai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:REG_IDX_LSB]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight <= WEIGHT_W'(WEIGHT_RESET);
      cfg.limit  <= LIMIT_W'(LIMIT_RESET);
    end else if (wr) begin
      case (idx)
        REG_WEIGHT: cfg.weight <= pwdata[WEIGHT_W-1:0];
        REG_LIMIT:  cfg.limit  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_WEIGHT: prdata = PDATA_W'(cfg.weight);
      REG_LIMIT:  prdata = PDATA_W'(cfg.limit);
      default:    prdata = '0;
    endcase
  end

endmodule

>>> sv/pai_div.sv
module pai_div import pai_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvs;
  logic [DIV_W-1:0]     quo;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W:0]      diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, try the divisor
  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
        rem  <= '0;
        dvs  <= req.divisor;
        quo  <= req.dividend;
      end else if (busy) begin
        rem <= fits ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dvs))
    else $error("divider remainder not below divisor");

  // Completion is flagged as the unit goes idle
  a_done_on_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("divider went idle without done");

endmodule

>>> sv/pai_mul.sv
module pai_mul import pai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mul_req_t           req,
  output logic               done,
  output logic [MUL_P_W-1:0] product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   a;
  logic [MUL_A_W-1:0]   hi;
  logic [MUL_B_W-1:0]   lo;
  logic [MUL_S_W-1:0]   sum;

  // One digit of the multiplier per cycle, low digit first
  assign sum = MUL_S_W'(hi) + MUL_S_W'(a) * MUL_S_W'(lo[DIGIT_W-1:0]);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MUL_DIGITS - 1);
        a    <= req.a;
        hi   <= '0;
        lo   <= req.b;
      end else if (busy) begin
        hi  <= sum[MUL_S_W-1:DIGIT_W];
        lo  <= {sum[DIGIT_W-1:0], lo[MUL_B_W-1:DIGIT_W]};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/predicted_angle_integrator_unit.sv
// Channel  Beat                                         Handshake
// sample   sample_t: start_series, time, angle          sample_valid / sample_ready
// result   result_t: elapsed, integral, first time      result_valid / result_ready
// apb      smoothing_weight @0x0, outlier_limit @0x4    psel, penable, pwrite; pready = 1
//
// One sample at a time. A sample that opens a series goes straight to the result.
// Otherwise a bit-serial divide for the new velocity, then two passes
// through the 4-bit-digit multiplier (mix, prediction).
// With a zero prior interval the divide and mix are skipped.
// Reset is synchronous; no series is open after reset.
// The result register frees the sample side; a stalled result only holds
// the final step until the register is taken.
module predicted_angle_integrator_unit import pai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  sample_t            sample,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t state, state_next;
  cfg_t   cfg;

  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quotient;
  mul_req_t           mul_req;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_product;

  // Series state
  logic                      started;
  logic [TIME_W-1:0]         last_time;
  logic signed [ANGLE_W-1:0] last_angle;
  logic signed [ANGLE_W-1:0] last_step;
  logic [TIME_W-1:0]         last_interval;
  logic signed [VEL_W-1:0]   vel;
  logic [TIME_W-1:0]         time_sum;
  logic signed [SUM_W-1:0]   angle_sum;
  logic [TIME_W-1:0]         series_start_time;

  // Per-sample working registers
  logic [TIME_W-1:0]         cur_time;
  logic signed [ANGLE_W-1:0] cur_angle;
  logic [TIME_W-1:0]         interval;
  logic signed [VEL_W-1:0]   nv;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [MIX_W-1:0]   mix;
  logic signed [ANGLE_W-1:0] wstep;
  logic signed [ANGLE_W-1:0] pred;
  logic signed [ANGLE_W-1:0] step;

  // Combinational helpers
  logic                      series_begin;
  logic [WEIGHT_W-1:0]       w_eff;
  logic [ANGLE_W-1:0]        last_step_mag;
  logic [QX_W-1:0]           qx;
  logic signed [VEL_W-1:0]   nv_sat;
  logic [DIFF_W-1:0]         diff_mag;
  logic signed [MIX_W-1:0]   mix_p;
  logic signed [MIX_W-1:0]   vel_x;
  logic signed [MIX_W-1:0]   mix_sum;
  logic signed [MIX_W-1:0]   mix_r;
  logic signed [VEL_W-1:0]   vel_mix;
  logic [VEL_W-1:0]          vel_mag;
  logic [PM_W-1:0]           pm;
  logic signed [ANGLE_W-1:0] pred_sat;
  logic signed [WRAP_W-1:0]  raw_step;
  logic signed [WRAP_W-1:0]  wrapped;
  logic [ANGLE_W-1:0]        wstep_mag;
  logic                      outlier;
  logic                      opposite;
  logic                      w_neg, w_pos, p_neg, p_pos;
  logic [TIME_W:0]           tsum;
  logic signed [SUM_W:0]     asum;

  pai_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pai_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  pai_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_product)
  );

  assign series_begin = sample.start_series || !started;
  assign w_eff = (cfg.weight > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : cfg.weight;

  // New velocity: signed quotient, saturated
  assign last_step_mag = last_step[ANGLE_W-1] ? ANGLE_W'(-last_step) : ANGLE_W'(last_step);
  assign qx = QX_W'(div_quotient);
  always_comb begin
    if (last_step[ANGLE_W-1]) begin
      nv_sat = (qx > QX_NEG_MAX) ? VEL_MIN : $signed(VEL_W'(QX_W'(0) - qx));
    end else begin
      nv_sat = (qx > QX_POS_MAX) ? VEL_MAX : $signed(VEL_W'(qx));
    end
  end

  // Mix: old * 256 + w * (new - old), then shift toward zero
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign mix_p    = $signed({1'b0, mul_product[MIX_P_W-1:0]});
  assign vel_x    = $signed({{(MIX_W-VEL_W){vel[VEL_W-1]}}, vel}) <<< WEIGHT_SHIFT;
  assign mix_sum  = diff[DIFF_W-1] ? (vel_x - mix_p) : (vel_x + mix_p);
  assign mix_r    = mix + (mix[MIX_W-1] ? MIX_W'(ROUND_BIAS) : MIX_W'(0));
  assign vel_mix  = $signed(mix_r[WEIGHT_SHIFT +: VEL_W]);

  // Prediction: |velocity| * interval, drop fraction, restore sign, saturate
  assign vel_mag = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
  assign pm      = mul_product[MUL_P_W-1:VEL_FRAC];
  always_comb begin
    if (vel[VEL_W-1]) begin
      pred_sat = (pm > PM_W'($unsigned(ANGLE_MIN))) ? ANGLE_MIN
                                                    : $signed(ANGLE_W'(PM_W'(0) - pm));
    end else begin
      pred_sat = (pm > PM_W'(ANGLE_MAX)) ? ANGLE_MAX : $signed(pm[ANGLE_W-1:0]);
    end
  end

  // Measured step with one wrap into plus or minus pi
  assign raw_step = WRAP_W'(cur_angle) - WRAP_W'(last_angle);
  always_comb begin
    if (raw_step > WRAP_W'(ANG_PI)) begin
      wrapped = raw_step - WRAP_W'(ANG_2PI);
    end else if (raw_step < -WRAP_W'(ANG_PI)) begin
      wrapped = raw_step + WRAP_W'(ANG_2PI);
    end else begin
      wrapped = raw_step;
    end
  end

  // Outlier and direction checks
  assign wstep_mag = wstep[ANGLE_W-1] ? ANGLE_W'(-wstep) : ANGLE_W'(wstep);
  assign w_neg     = wstep[ANGLE_W-1];
  assign w_pos     = !wstep[ANGLE_W-1] && (wstep != '0);
  assign p_neg     = pred[ANGLE_W-1];
  assign p_pos     = !pred[ANGLE_W-1] && (pred != '0);
  assign outlier   = wstep_mag > ANGLE_W'(cfg.limit);
  assign opposite  = (w_neg && p_pos) || (w_pos && p_neg);

  // Saturating sums
  assign tsum = {1'b0, time_sum} + {1'b0, interval};
  assign asum = $signed({angle_sum[SUM_W-1], angle_sum})
              + $signed({{(SUM_W+1-ANGLE_W){step[ANGLE_W-1]}}, step});

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next       = state;
    sample_ready     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {last_step_mag, {VEL_FRAC{1'b0}}};
    div_req.divisor  = last_interval;
    mul_req.start    = 1'b0;
    mul_req.a        = MUL_A_W'(vel_mag);
    mul_req.b        = interval;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          if (series_begin) begin
            state_next = ST_OUT;
          end else if (last_interval != '0) begin
            div_req.start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            state_next = ST_PRED_GO;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_DIFF;
      end
      ST_DIFF: begin
        state_next = ST_MIX_GO;
      end
      ST_MIX_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(diff_mag);
        mul_req.b     = MUL_B_W'(w_eff);
        state_next    = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        if (mul_done) state_next = ST_MIX_SHR;
      end
      ST_MIX_SHR: begin
        state_next = ST_PRED_GO;
      end
      ST_PRED_GO: begin
        mul_req.start = 1'b1;
        state_next    = ST_PRED_MUL;
      end
      ST_PRED_MUL: begin
        if (mul_done) state_next = ST_STEP;
      end
      ST_STEP: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!result_valid || result_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != ST_OUT)) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            cur_time  <= sample.sample_time;
            cur_angle <= sample.sample_angle;
            interval  <= sample.sample_time - last_time;
            if (series_begin) begin
              started           <= 1'b1;
              series_start_time <= sample.sample_time;
              last_time         <= sample.sample_time;
              last_angle        <= sample.sample_angle;
              last_step         <= '0;
              last_interval     <= TIME_W'(1);
              vel               <= '0;
              time_sum          <= '0;
              angle_sum         <= '0;
            end
          end
        end
        ST_DIV: begin
          if (div_done) nv <= nv_sat;
        end
        ST_DIFF: begin
          diff <= DIFF_W'(nv) - DIFF_W'(vel);
        end
        ST_MIX_MUL: begin
          if (mul_done) mix <= mix_sum;
        end
        ST_MIX_SHR: begin
          vel <= vel_mix;
        end
        ST_PRED_GO: begin
          wstep <= $signed(wrapped[ANGLE_W-1:0]);
        end
        ST_PRED_MUL: begin
          if (mul_done) pred <= pred_sat;
        end
        ST_STEP: begin
          step <= (outlier || opposite) ? pred : wstep;
        end
        ST_SUM: begin
          time_sum <= tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
          if (asum[SUM_W] != asum[SUM_W-1]) begin
            angle_sum <= asum[SUM_W] ? SUM_MIN : SUM_MAX;
          end else begin
            angle_sum <= $signed(asum[SUM_W-1:0]);
          end
          last_step     <= step;
          last_interval <= interval;
          last_time     <= cur_time;
          last_angle    <= cur_angle;
        end
        ST_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid             <= 1'b1;
            result.elapsed_time      <= time_sum;
            result.integrated_angle  <= angle_sum;
            result.first_sample_time <= series_start_time;
          end
        end
        default: ;
      endcase
    end
  end

  // Leaving the final step always presents a result
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!result_valid || result_ready)) |=> result_valid)
    else $error("result not loaded on completion");

  // One sample in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("sample accepted while busy");

endmodule

>>> dv/predicted_angle_integrator_unit_tb.sv
`timescale 1ns / 1ps

module predicted_angle_integrator_unit_tb;
  import pai_pkg::*;

  localparam int VEL_FRAC_BITS = 16;
  localparam int HALF_TURN     = 25736;
  localparam int FULL_TURN     = 51472;
  localparam int RESET_WEIGHT  = 218;
  localparam int RESET_LIMIT   = 1638;
  localparam longint WEIGHT_FULL = 256;
  localparam longint S16_MIN = -64'sd32768;
  localparam longint S16_MAX = 64'sd32767;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint U32_MAX = 64'sd4294967295;

  localparam int IDLE_PCT      = 74;
  localparam int BOTH_IDLE_PCT = 21;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD_OFF = 600;
  localparam int PHASE_ITEMS   = 210;
  localparam int NUM_PHASES    = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Integrator model: tracks the block's state and queues the expected beats
  class angle_scoreboard;
    logic [WEIGHT_W-1:0] weight;
    logic [LIMIT_W-1:0]  limit;
    bit                  started;
    logic [TIME_W-1:0]   last_time;
    int                  last_angle;
    int                  last_step;
    logic [TIME_W-1:0]   last_interval;
    int                  velocity;
    logic [TIME_W-1:0]   time_sum;
    int                  angle_sum;
    logic [TIME_W-1:0]   series_first;
    result_t             expected_q[$];
    int                  errors;

    function new();
      weight        = RESET_WEIGHT;
      limit         = RESET_LIMIT;
      started       = 1'b0;
      last_time     = '0;
      last_angle    = 0;
      last_step     = 0;
      last_interval = 1;
      velocity      = 0;
      time_sum      = '0;
      angle_sum     = 0;
      series_first  = '0;
      errors        = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_WEIGHT: weight = value[WEIGHT_W-1:0];
        REG_LIMIT:  limit  = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint div_toward_zero(longint v, longint d);
      longint q;
      q = ((v < 0) ? -v : v) / d;
      return (v < 0) ? -q : q;
    endfunction

    function longint shr_toward_zero(longint v, int sh);
      longint q;
      q = ((v < 0) ? -v : v) >> sh;
      return (v < 0) ? -q : q;
    endfunction

    function void note_sample(sample_t s);
      longint w, nv, mix, pred, delta, ival, tsum, asum;
      logic [TIME_W-1:0] interval;
      result_t want;
      if (s.start_series || !started) begin
        // series start clears velocity, step and both sums
        started       = 1'b1;
        series_first  = s.sample_time;
        last_time     = s.sample_time;
        last_angle    = int'($signed(s.sample_angle));
        last_step     = 0;
        last_interval = 1;
        velocity      = 0;
        time_sum      = '0;
        angle_sum     = 0;
      end else begin
        w = (weight > WEIGHT_FULL) ? WEIGHT_FULL : longint'({55'b0, weight});
        // smoothed velocity; held across a zero prior interval
        if (last_interval != 0) begin
          nv = div_toward_zero(longint'(last_step) * (longint'(1) << VEL_FRAC_BITS),
                               longint'({32'b0, last_interval}));
          nv = clamp(nv, S32_MIN, S32_MAX);
          mix = w * nv + (WEIGHT_FULL - w) * longint'(velocity);
          velocity = int'(clamp(shr_toward_zero(mix, 8), S32_MIN, S32_MAX));
        end
        interval = s.sample_time - last_time;
        ival = longint'({32'b0, interval});
        pred = shr_toward_zero(longint'(velocity) * ival, VEL_FRAC_BITS);
        pred = clamp(pred, S16_MIN, S16_MAX);
        // measured step, one wrap into +/- pi
        delta = longint'(int'($signed(s.sample_angle))) - longint'(last_angle);
        if (delta > HALF_TURN) delta -= FULL_TURN;
        else if (delta < -HALF_TURN) delta += FULL_TURN;
        // outlier or reversed step falls back on the prediction
        if (((delta < 0) ? -delta : delta) > longint'({49'b0, limit}) ||
            (delta < 0 && pred > 0) || (delta > 0 && pred < 0))
          delta = pred;
        tsum = longint'({32'b0, time_sum}) + ival;
        time_sum = TIME_W'(clamp(tsum, 0, U32_MAX));
        asum = longint'(angle_sum) + delta;
        angle_sum = int'(clamp(asum, S32_MIN, S32_MAX));
        last_step     = int'(delta);
        last_interval = interval;
        last_time     = s.sample_time;
        last_angle    = int'($signed(s.sample_angle));
      end
      want.elapsed_time      = time_sum;
      want.integrated_angle  = angle_sum;
      want.first_sample_time = series_first;
      expected_q.insert(expected_q.size(), want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t r);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %h", $time, r);
        return;
      end
      want = expected_q.pop_front();
      compare_field("elapsed_time", want.elapsed_time, r.elapsed_time);
      compare_field("integrated_angle", want.integrated_angle, r.integrated_angle);
      compare_field("first_sample_time", want.first_sample_time, r.first_sample_time);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_ready;
  sample_t            sample;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  angle_scoreboard sb = new();
  idle_mode_t      idle_mode = IDLE_NONE;
  int              hold_off_request = 0;
  int              cycle_count = 0;

  predicted_angle_integrator_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit idle_draw(input bit for_sender);
    int pct;
    case (idle_mode)
      IDLE_SENDER:   pct = for_sender ? IDLE_PCT : 0;
      IDLE_RECEIVER: pct = for_sender ? 0 : IDLE_PCT;
      IDLE_BOTH:     pct = BOTH_IDLE_PCT;
      default:       pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request != 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !idle_draw(1'b0);
      end
    end
  end

  // Monitor both channels at the rising edge; watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && sample_valid && sample_ready) sb.note_sample(sample);
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, sb.expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one sample beat; entered and left at a falling edge
  task automatic send_sample(input bit st, input logic [TIME_W-1:0] t, input int a);
    sample_t beat;
    beat.start_series = st;
    beat.sample_time  = t;
    beat.sample_angle = a[ANGLE_W-1:0];
    while (idle_draw(1'b1)) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= beat;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // APB write; psel stays up so writes can go back to back
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly coherent series with random drift and clock noise, some stray beats
  task automatic random_traffic(input int count);
    int sent, len, k, drift, base_dt, d, ang, pick;
    logic [TIME_W-1:0] t;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(19) == 0) begin
        send_sample(1'($urandom_range(1)), $urandom,
                    int'($urandom_range(FULL_TURN)) - HALF_TURN);
        sent++;
      end else begin
        t       = $urandom;
        ang     = int'($urandom_range(FULL_TURN)) - HALF_TURN;
        drift   = int'($urandom_range(6000)) - 3000;
        base_dt = $urandom_range(1) ? int'($urandom_range(1, 64))
                                    : int'($urandom_range(500, 40000));
        len     = $urandom_range(2, 40);
        // a few series continue without the start flag
        send_sample($urandom_range(7) != 0, t, ang);
        sent++;
        for (k = 1; k < len && sent < count; k++) begin
          pick = $urandom_range(99);
          if (pick >= 10) t = t + base_dt + $urandom_range(base_dt / 8);
          else if (pick >= 6) t = t + $urandom;
          else if (pick >= 3) t = t - $urandom_range(1, 1000);
          // else same timestamp: zero interval
          pick = $urandom_range(99);
          d = drift + int'($urandom_range(40)) - 20;
          if (pick < 5) d = -d;
          else if (pick < 10) d = int'($urandom_range(HALF_TURN - 1)) * ($urandom_range(1) ? 1 : -1);
          ang = ang + d;
          if (ang > HALF_TURN) ang -= FULL_TURN;
          else if (ang < -HALF_TURN) ang += FULL_TURN;
          send_sample(1'b0, t, ang);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int p, w, l;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, no idling
    send_sample(1'b0, 32'd1000, 0);            // first beat opens a series without the flag
    send_sample(1'b0, 32'd2000, 100);
    send_sample(1'b0, 32'd3000, 300);
    send_sample(1'b0, 32'd3000, 400);          // zero interval
    send_sample(1'b0, 32'd4000, 500);          // zero prior interval holds velocity
    send_sample(1'b0, 32'd5000, 4000);         // outlier
    send_sample(1'b0, 32'd6000, 3900);         // reversed step
    send_sample(1'b0, 32'd7000, 3900);         // zero step
    send_sample(1'b0, 32'd5500, 4100);         // time going backwards
    send_sample(1'b1, 32'hFFFF_FFF0, 25000);
    send_sample(1'b0, 32'h0000_0010, -25000);  // timestamp wraps, step wraps up
    send_sample(1'b0, 32'h0000_0100, 25000);   // step wraps down
    send_sample(1'b0, 32'h0000_0200, HALF_TURN);
    send_sample(1'b0, 32'h0000_0300, -HALF_TURN);
    send_sample(1'b1, 32'h0000_0000, -HALF_TURN);
    send_sample(1'b0, 32'hFFFF_FFFF, -25000);  // largest interval
    send_sample(1'b0, 32'h7FFF_FFFF, -24000);  // elapsed time saturates
    send_sample(1'b1, 32'h8000_0000, 0);
    send_sample(1'b0, 32'h8000_0001, 1600);    // fast spin, prediction clamps
    send_sample(1'b0, 32'h8000_0002, 3200);
    send_sample(1'b0, 32'h8000_C352, 12000);
    send_sample(1'b0, 32'h8001_0000, -20000);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          w = 0;
          l = 0;
        end
        1: begin
          w = int'(WEIGHT_FULL);
          l = HALF_TURN;
        end
        2: begin
          w = 511;                             // above full weight
          l = RESET_LIMIT;
        end
        3: begin
          w = 1;
          l = 1;
        end
        4: begin
          w = 128;
          l = 4000;
        end
        default: begin
          w = $urandom_range(300);
          l = $urandom_range(HALF_TURN);
        end
      endcase
      write_reg(REG_WEIGHT, w);
      write_reg(REG_LIMIT, l);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      idle_mode = idle_mode_t'(p % 4);
      // back-pressure: result side goes quiet while samples keep coming
      if (p == 4) hold_off_request = LONG_HOLD_OFF;
      random_traffic(PHASE_ITEMS);
      drain();
    end

    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
sv/pai_pkg.sv
sv/pai_cfg.sv
sv/pai_div.sv
sv/pai_mul.sv
sv/predicted_angle_integrator_unit.sv
dv/predicted_angle_integrator_unit_tb.sv
